[hw/rtl/owmm_pkg.sv]
// Shared types, constants and coefficient table for the omni wheel motor mixer.
`default_nettype none

package owmm_pkg;

    localparam int HEAD_W      = 10;
    localparam int SPEED_W     = 9;
    localparam int ANGLE_W     = 9;
    localparam int COEF_W      = 16;
    localparam int MAG_W       = 15;
    localparam int QIDX_W      = 7;
    localparam int FRAC_BITS   = 14;
    localparam int PROD_W      = SPEED_W + COEF_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int Q_W         = ACC_W - FRAC_BITS;
    localparam int DUTY_W      = 8;
    localparam int NUM_WHEELS  = 4;

    localparam int DUTY_MAX_DEF = 255;

    localparam int FULL_TURN   = 360;
    localparam int THREE_QTR   = 270;
    localparam int HALF_TURN   = 180;
    localparam int QTR_TURN    = 90;
    localparam int OFFSET_DEG  = 30;
    localparam int COEF_MAX    = 18919;

    localparam int LANE_LF = 0;
    localparam int LANE_LB = 1;
    localparam int LANE_RF = 2;
    localparam int LANE_RB = 3;

    // sin(d)/sin(120) in unsigned Q1.14 for d = 0..90
    localparam logic [MAG_W-1:0] QTAB [0:QTR_TURN] = '{
        15'd0,     15'd330,   15'd660,   15'd990,   15'd1320,
        15'd1649,  15'd1978,  15'd2306,  15'd2633,  15'd2960,
        15'd3285,  15'd3610,  15'd3933,  15'd4256,  15'd4577,
        15'd4897,  15'd5215,  15'd5531,  15'd5846,  15'd6159,
        15'd6471,  15'd6780,  15'd7087,  15'd7392,  15'd7695,
        15'd7995,  15'd8293,  15'd8589,  15'd8882,  15'd9172,
        15'd9459,  15'd9744,  15'd10025, 15'd10304, 15'd10579,
        15'd10851, 15'd11120, 15'd11386, 15'd11648, 15'd11906,
        15'd12161, 15'd12412, 15'd12659, 15'd12903, 15'd13142,
        15'd13378, 15'd13609, 15'd13836, 15'd14059, 15'd14278,
        15'd14493, 15'd14703, 15'd14908, 15'd15109, 15'd15306,
        15'd15497, 15'd15684, 15'd15867, 15'd16044, 15'd16217,
        15'd16384, 15'd16547, 15'd16704, 15'd16857, 15'd17004,
        15'd17146, 15'd17283, 15'd17415, 15'd17541, 15'd17662,
        15'd17778, 15'd17888, 15'd17993, 15'd18092, 15'd18186,
        15'd18274, 15'd18357, 15'd18434, 15'd18505, 15'd18571,
        15'd18631, 15'd18686, 15'd18735, 15'd18778, 15'd18815,
        15'd18847, 15'd18873, 15'd18893, 15'd18907, 15'd18916,
        15'd18919
    };

    typedef struct packed {
        logic signed [COEF_W-1:0]  k1;
        logic signed [COEF_W-1:0]  k2;
        logic signed [SPEED_W-1:0] base;
        logic signed [SPEED_W-1:0] spin;
    } coef_t;

    typedef struct packed {
        logic signed [PROD_W-1:0]  p1;
        logic signed [PROD_W-1:0]  p2;
        logic signed [SPEED_W-1:0] spin;
    } prod_t;

    // Full-circle coefficient for an angle already folded to 0..359.
    function automatic logic signed [COEF_W-1:0] coef_lookup(input logic [ANGLE_W-1:0] d);
        logic [ANGLE_W-1:0] idx;
        logic               neg;
        logic [MAG_W-1:0]   mag;
        logic [COEF_W-1:0]  ext;
        if (d <= ANGLE_W'(QTR_TURN))
        begin
            idx = d;
            neg = 1'b0;
        end
        else if (d <= ANGLE_W'(HALF_TURN))
        begin
            idx = ANGLE_W'(HALF_TURN) - d;
            neg = 1'b0;
        end
        else if (d <= ANGLE_W'(THREE_QTR))
        begin
            idx = d - ANGLE_W'(HALF_TURN);
            neg = 1'b1;
        end
        else
        begin
            idx = ANGLE_W'(FULL_TURN) - d;
            neg = 1'b1;
        end
        mag = QTAB[idx[QIDX_W-1:0]];
        ext = {1'b0, mag};
        return neg ? -$signed(ext) : $signed(ext);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/omni_wheel_motor_mixer_unit.sv]
// Top level of the omni wheel motor mixer: heading and speeds in, four wheel drives out.
//
// One command transfers on each clock edge with start high; busy never rises, so a new
// command may follow every cycle. The wheel results appear after the registered stages
// fold, coefficient lookup, multiply, spin mix and truncate, and saturate, each result
// held for one cycle with done high. The receiver must take each result in that cycle.
`default_nettype none

module omni_wheel_motor_mixer_unit #(
    parameter int DUTY_MAX = owmm_pkg::DUTY_MAX_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [owmm_pkg::HEAD_W-1:0]  heading_deg,
    input  wire logic signed [owmm_pkg::SPEED_W-1:0] base_speed,
    input  wire logic signed [owmm_pkg::SPEED_W-1:0] spin_speed,
    output logic                                     done,
    output logic [owmm_pkg::DUTY_W-1:0]              lf_duty,
    output logic                                     lf_reverse,
    output logic [owmm_pkg::DUTY_W-1:0]              lb_duty,
    output logic                                     lb_reverse,
    output logic [owmm_pkg::DUTY_W-1:0]              rf_duty,
    output logic                                     rf_reverse,
    output logic [owmm_pkg::DUTY_W-1:0]              rb_duty,
    output logic                                     rb_reverse
);
    import owmm_pkg::*;

    logic              coef_valid;
    coef_t             coef;
    logic              prod_valid;
    prod_t             prod;
    logic [DUTY_W-1:0] duty [NUM_WHEELS];
    logic              reverse [NUM_WHEELS];

    assign busy = 1'b0;

    owmm_angle u_angle (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .heading_deg (heading_deg),
        .base_speed  (base_speed),
        .spin_speed  (spin_speed),
        .out_valid   (coef_valid),
        .out_coef    (coef)
    );

    owmm_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (coef_valid),
        .in_coef   (coef),
        .out_valid (prod_valid),
        .out_prod  (prod)
    );

    owmm_drive #(
        .DUTY_MAX (DUTY_MAX)
    ) u_drive (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_prod   (prod),
        .out_valid (done),
        .duty      (duty),
        .reverse   (reverse)
    );

    assign lf_duty    = duty[LANE_LF];
    assign lf_reverse = reverse[LANE_LF];
    assign lb_duty    = duty[LANE_LB];
    assign lb_reverse = reverse[LANE_LB];
    assign rf_duty    = duty[LANE_RF];
    assign rf_reverse = reverse[LANE_RF];
    assign rb_duty    = duty[LANE_RB];
    assign rb_reverse = reverse[LANE_RB];

endmodule

`default_nettype wire

[hw/rtl/owmm_angle.sv]
// Heading fold and coefficient lookup stages of the omni wheel mixer.
`default_nettype none

module owmm_angle (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic signed [owmm_pkg::HEAD_W-1:0]  heading_deg,
    input  wire logic signed [owmm_pkg::SPEED_W-1:0] base_speed,
    input  wire logic signed [owmm_pkg::SPEED_W-1:0] spin_speed,
    output logic                                  out_valid,
    output owmm_pkg::coef_t                       out_coef
);
    import owmm_pkg::*;

    localparam int WRAP_W = HEAD_W + 2;

    logic                      v1_reg, v1_next;
    logic [ANGLE_W-1:0]        a_reg, a_next;
    logic signed [SPEED_W-1:0] base1_reg, spin1_reg;

    logic                      v2_reg, v2_next;
    coef_t                     coef_reg, coef_next;

    logic signed [WRAP_W-1:0]  wrapped;
    logic [WRAP_W-2:0]         w0, w1, w2;
    logic signed [ANGLE_W:0]   t1;
    logic [ANGLE_W:0]          t2;
    logic [ANGLE_W-1:0]        idx1, idx2;

    // fold heading to 0..359
    always_comb
    begin
        wrapped = WRAP_W'(heading_deg) + WRAP_W'(2 * FULL_TURN);
        w0      = wrapped[WRAP_W-2:0];
        w1      = (w0 >= (WRAP_W-1)'(2 * FULL_TURN)) ? w0 - (WRAP_W-1)'(2 * FULL_TURN) : w0;
        w2      = (w1 >= (WRAP_W-1)'(FULL_TURN)) ? w1 - (WRAP_W-1)'(FULL_TURN) : w1;
        a_next  = w2[ANGLE_W-1:0];
        v1_next = in_valid;
    end

    always_comb
    begin
        t1   = (ANGLE_W+1)'(OFFSET_DEG) - $signed({1'b0, a_reg});
        idx1 = (t1 < 0) ? ANGLE_W'(t1 + (ANGLE_W+1)'(FULL_TURN)) : ANGLE_W'(t1);
        t2   = {1'b0, a_reg} + (ANGLE_W+1)'(OFFSET_DEG);
        idx2 = (t2 >= (ANGLE_W+1)'(FULL_TURN)) ? ANGLE_W'(t2 - (ANGLE_W+1)'(FULL_TURN))
                                               : ANGLE_W'(t2);
        coef_next.k1   = coef_lookup(idx1);
        coef_next.k2   = coef_lookup(idx2);
        coef_next.base = base1_reg;
        coef_next.spin = spin1_reg;
        v2_next        = v1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        base1_reg <= base_speed;
        spin1_reg <= spin_speed;
        coef_reg  <= coef_next;
    end

    assign out_valid = v2_reg;
    assign out_coef  = coef_reg;

    a_folded_range: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> a_reg < ANGLE_W'(FULL_TURN))
        else $error("folded heading out of range");

    a_k1_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (coef_reg.k1 <= COEF_W'(COEF_MAX)) && (coef_reg.k1 >= -COEF_W'(COEF_MAX)))
        else $error("k1 beyond table bound");

    a_k2_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (coef_reg.k2 <= COEF_W'(COEF_MAX)) && (coef_reg.k2 >= -COEF_W'(COEF_MAX)))
        else $error("k2 beyond table bound");

endmodule

`default_nettype wire

[hw/rtl/owmm_scale.sv]
// Coefficient multiply stage of the omni wheel mixer.
`default_nettype none

module owmm_scale (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire owmm_pkg::coef_t  in_coef,
    output logic                  out_valid,
    output owmm_pkg::prod_t       out_prod
);
    import owmm_pkg::*;

    logic  v3_reg, v3_next;
    prod_t prod_reg, prod_next;

    always_comb
    begin
        prod_next.p1   = PROD_W'(in_coef.base) * PROD_W'(in_coef.k1);
        prod_next.p2   = PROD_W'(in_coef.base) * PROD_W'(in_coef.k2);
        prod_next.spin = in_coef.spin;
        v3_next        = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign out_valid = v3_reg;
    assign out_prod  = prod_reg;

endmodule

`default_nettype wire

[hw/rtl/owmm_drive.sv]
// Spin mix, truncation and saturation stages of the omni wheel mixer.
`default_nettype none

module owmm_drive #(
    parameter int DUTY_MAX = owmm_pkg::DUTY_MAX_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire owmm_pkg::prod_t  in_prod,
    output logic                  out_valid,
    output logic [owmm_pkg::DUTY_W-1:0] duty [owmm_pkg::NUM_WHEELS],
    output logic                  reverse [owmm_pkg::NUM_WHEELS]
);
    import owmm_pkg::*;

    localparam int DMAX_BITS = $clog2(DUTY_MAX + 1);
    localparam int CW        = ((DMAX_BITS > Q_W) ? DMAX_BITS : Q_W) + 1;
    localparam logic signed [CW-1:0] DMAX_S = CW'(DUTY_MAX);
    localparam int Q_LIMIT   = 1 << (Q_W - 2);

    logic                      v4_reg, v4_next;
    logic signed [Q_W-1:0]     q_reg [NUM_WHEELS];
    logic signed [Q_W-1:0]     q_next [NUM_WHEELS];

    logic                      v5_reg, v5_next;
    logic [DUTY_W-1:0]         duty_reg [NUM_WHEELS];
    logic [DUTY_W-1:0]         duty_next [NUM_WHEELS];
    logic                      rev_reg [NUM_WHEELS];
    logic                      rev_next [NUM_WHEELS];

    logic signed [ACC_W-1:0]   spin_ext;
    logic signed [ACC_W-1:0]   p1_ext, p2_ext;
    logic signed [ACC_W-1:0]   acc [NUM_WHEELS];
    logic signed [CW-1:0]      qx [NUM_WHEELS];
    logic signed [CW-1:0]      cl [NUM_WHEELS];
    logic signed [CW-1:0]      mag [NUM_WHEELS];

    // mix spin term, truncate toward zero
    always_comb
    begin
        spin_ext = {{(ACC_W - SPEED_W - FRAC_BITS){in_prod.spin[SPEED_W-1]}},
                    in_prod.spin, {FRAC_BITS{1'b0}}};
        p1_ext   = ACC_W'(in_prod.p1);
        p2_ext   = ACC_W'(in_prod.p2);
        acc[LANE_LF] = p2_ext + spin_ext;
        acc[LANE_LB] = p1_ext + spin_ext;
        acc[LANE_RF] = p1_ext - spin_ext;
        acc[LANE_RB] = p2_ext - spin_ext;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            q_next[i] = acc[i][ACC_W-1:FRAC_BITS]
                      + Q_W'(acc[i][ACC_W-1] && (|acc[i][FRAC_BITS-1:0]));
        end
        v4_next = in_valid;
    end

    // saturate and split into magnitude and direction
    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            qx[i] = CW'(q_reg[i]);
            if (qx[i] > DMAX_S)
            begin
                cl[i] = DMAX_S;
            end
            else if (qx[i] < -DMAX_S)
            begin
                cl[i] = -DMAX_S;
            end
            else
            begin
                cl[i] = qx[i];
            end
            mag[i]       = (cl[i] < 0) ? -cl[i] : cl[i];
            duty_next[i] = mag[i][DUTY_W-1:0];
            rev_next[i]  = cl[i] < 0;
        end
        v5_next = v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            q_reg[i]    <= q_next[i];
            duty_reg[i] <= duty_next[i];
            rev_reg[i]  <= rev_next[i];
        end
    end

    assign out_valid = v5_reg;
    assign duty      = duty_reg;
    assign reverse   = rev_reg;

    a_lf_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (q_reg[LANE_LF] < Q_W'(Q_LIMIT)) && (q_reg[LANE_LF] > -Q_W'(Q_LIMIT)))
        else $error("left front quotient out of range");

    a_rb_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (q_reg[LANE_RB] < Q_W'(Q_LIMIT)) && (q_reg[LANE_RB] > -Q_W'(Q_LIMIT)))
        else $error("right back quotient out of range");

    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |=> v5_reg)
        else $error("result lost between quotient and output stage");

endmodule

`default_nettype wire
